// ----- src/tdpa_pkg.sv -----
// Shared types and codes for the text delta patch applier.
`timescale 1ns / 1ps

package tdpa_pkg;

	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_NUM    = 8'b0000_0010,
		PH_OP     = 8'b0000_0100,
		PH_COPY   = 8'b0000_1000,
		PH_SKIP   = 8'b0001_0000,
		PH_INSERT = 8'b0010_0000,
		PH_DELIM  = 8'b0100_0000,
		PH_END    = 8'b1000_0000
	} phase_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_DELTA = 2'd1,
		OP_OLD   = 2'd2,
		OP_EOD   = 2'd3
	} item_op_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OVERRUN   = 3'd1;
	localparam logic [2:0] ST_DELIM     = 3'd2;
	localparam logic [2:0] ST_UNKNOWN   = 3'd3;
	localparam logic [2:0] ST_MALFORMED = 3'd4;
	localparam logic [2:0] ST_MISMATCH  = 3'd5;
	localparam logic [2:0] ST_KIND      = 3'd6;

	localparam logic [1:0] NEED_DELTA = 2'd0;
	localparam logic [1:0] NEED_OLD   = 2'd1;
	localparam logic [1:0] NEED_NONE  = 2'd2;

	localparam logic [7:0] CH_COPY  = 8'h3D;
	localparam logic [7:0] CH_SKIP  = 8'h2D;
	localparam logic [7:0] CH_INS   = 8'h2B;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic [1:0] need_next;
		logic       done_res;
		logic [2:0] status;
	} result_t;

endpackage

// ----- src/tdpa_core.sv -----
// Patch state machine: job state registers and the one-word step logic.
`timescale 1ns / 1ps

module tdpa_core #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [1:0]          op,
	input  logic [31:0]         data,
	output tdpa_pkg::result_t   result
);

	localparam int L = LENGTH_BITS;

	tdpa_pkg::phase_t phase_q, phase_d;
	logic [L-1:0]     acc_q, acc_d;
	logic [L-1:0]     rem_q, rem_d;
	logic [L-1:0]     pos_q, pos_d;
	logic [L-1:0]     size_q, size_d;
	logic             digits_q, digits_d;
	logic             token_q, token_d;
	logic [2:0]       err_q, err_d;

	logic [7:0]       c;
	logic             blank;
	logic             is_digit;
	logic [L+3:0]     acc_x10;
	logic [L:0]       pos_sum;
	logic             overrun;
	logic             emit;
	logic [7:0]       emit_byte;

	tdpa_pkg::phase_t tk_phase;
	logic [2:0]       tk_err;
	logic             tk_clear;

	assign c        = data[7:0];
	assign blank    = (c == tdpa_pkg::CH_SPACE) ||
		(c >= tdpa_pkg::CH_TAB && c <= tdpa_pkg::CH_CR);
	assign is_digit = (c >= tdpa_pkg::CH_ZERO) && (c <= tdpa_pkg::CH_NINE);
	assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
		{{L{1'b0}}, c[3:0]};
	assign pos_sum  = {1'b0, pos_q} + {1'b0, acc_q};
	assign overrun  = pos_sum > {1'b0, size_q};

	// op character: choose the next phase
	always_comb begin
		tk_phase = phase_q;
		tk_err   = err_q;
		tk_clear = 1'b0;
		priority if (c == tdpa_pkg::CH_COPY || c == tdpa_pkg::CH_SKIP) begin
			priority if (overrun) begin
				tk_phase = tdpa_pkg::PH_END;
				tk_err   = tdpa_pkg::ST_OVERRUN;
			end else if (acc_q == '0) begin
				tk_phase = tdpa_pkg::PH_NUM;
				tk_clear = 1'b1;
			end else begin
				tk_phase = (c == tdpa_pkg::CH_COPY) ? tdpa_pkg::PH_COPY : tdpa_pkg::PH_SKIP;
			end
		end else if (c == tdpa_pkg::CH_INS) begin
			tk_phase = (acc_q == '0) ? tdpa_pkg::PH_DELIM : tdpa_pkg::PH_INSERT;
		end else begin
			tk_phase = tdpa_pkg::PH_END;
			tk_err   = tdpa_pkg::ST_UNKNOWN;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		rem_d     = rem_q;
		pos_d     = pos_q;
		size_d    = size_q;
		digits_d  = digits_q;
		token_d   = token_q;
		err_d     = err_q;
		emit      = 1'b0;
		emit_byte = 8'h00;

		priority if (op == tdpa_pkg::OP_START) begin
			phase_d  = tdpa_pkg::PH_NUM;
			acc_d    = '0;
			rem_d    = '0;
			pos_d    = '0;
			size_d   = data[L-1:0];
			digits_d = 1'b0;
			token_d  = 1'b0;
			err_d    = tdpa_pkg::ST_OK;
		end else if (phase_q == tdpa_pkg::PH_END && err_q != tdpa_pkg::ST_OK) begin
			phase_d = phase_q;
		end else if (phase_q == tdpa_pkg::PH_IDLE || phase_q == tdpa_pkg::PH_END) begin
			phase_d = tdpa_pkg::PH_END;
			err_d   = tdpa_pkg::ST_KIND;
		end else if (op == tdpa_pkg::OP_DELTA) begin
			unique case (phase_q)
				tdpa_pkg::PH_NUM: begin
					priority if (blank) begin
						if (digits_q) begin
							phase_d = tdpa_pkg::PH_OP;
						end else begin
							token_d = 1'b1;
						end
					end else if (is_digit) begin
						if (acc_x10[L+3:L] != 4'd0) begin
							phase_d = tdpa_pkg::PH_END;
							err_d   = tdpa_pkg::ST_MALFORMED;
						end else begin
							acc_d    = acc_x10[L-1:0];
							digits_d = 1'b1;
							token_d  = 1'b1;
						end
					end else if (digits_q) begin
						phase_d = tk_phase;
						err_d   = tk_err;
						rem_d   = acc_q;
						if (tk_clear) begin
							acc_d    = '0;
							digits_d = 1'b0;
							token_d  = 1'b0;
						end
					end else begin
						phase_d = tdpa_pkg::PH_END;
						err_d   = tdpa_pkg::ST_MALFORMED;
					end
				end
				tdpa_pkg::PH_OP: begin
					if (!blank) begin
						phase_d = tk_phase;
						err_d   = tk_err;
						rem_d   = acc_q;
						if (tk_clear) begin
							acc_d    = '0;
							digits_d = 1'b0;
							token_d  = 1'b0;
						end
					end
				end
				tdpa_pkg::PH_INSERT: begin
					emit      = 1'b1;
					emit_byte = c;
					rem_d     = rem_q - L'(1);
					if (rem_q == L'(1)) begin
						phase_d = tdpa_pkg::PH_DELIM;
					end
				end
				tdpa_pkg::PH_DELIM: begin
					priority if (blank) begin
						phase_d = phase_q;
					end else if (c == tdpa_pkg::CH_BAR) begin
						phase_d  = tdpa_pkg::PH_NUM;
						acc_d    = '0;
						digits_d = 1'b0;
						token_d  = 1'b0;
					end else begin
						phase_d = tdpa_pkg::PH_END;
						err_d   = tdpa_pkg::ST_DELIM;
					end
				end
				default: begin
					phase_d = tdpa_pkg::PH_END;
					err_d   = tdpa_pkg::ST_KIND;
				end
			endcase
		end else if (op == tdpa_pkg::OP_OLD) begin
			if (phase_q == tdpa_pkg::PH_COPY || phase_q == tdpa_pkg::PH_SKIP) begin
				emit      = (phase_q == tdpa_pkg::PH_COPY);
				emit_byte = (phase_q == tdpa_pkg::PH_COPY) ? c : 8'h00;
				pos_d     = pos_q + L'(1);
				rem_d     = rem_q - L'(1);
				if (rem_q == L'(1)) begin
					phase_d  = tdpa_pkg::PH_NUM;
					acc_d    = '0;
					digits_d = 1'b0;
					token_d  = 1'b0;
				end
			end else begin
				phase_d = tdpa_pkg::PH_END;
				err_d   = tdpa_pkg::ST_KIND;
			end
		end else begin
			phase_d = tdpa_pkg::PH_END;
			priority if (phase_q == tdpa_pkg::PH_NUM) begin
				priority if (token_q) begin
					err_d = tdpa_pkg::ST_MALFORMED;
				end else if (pos_q != size_q) begin
					err_d = tdpa_pkg::ST_MISMATCH;
				end else begin
					err_d = tdpa_pkg::ST_OK;
				end
			end else if (phase_q == tdpa_pkg::PH_OP || phase_q == tdpa_pkg::PH_INSERT ||
				phase_q == tdpa_pkg::PH_DELIM) begin
				err_d = tdpa_pkg::ST_MALFORMED;
			end else begin
				err_d = tdpa_pkg::ST_KIND;
			end
		end
	end

	always_comb begin
		result.out_valid = emit;
		result.out_byte  = emit_byte;
		result.done_res  = (phase_d == tdpa_pkg::PH_END) && (err_d == tdpa_pkg::ST_OK);
		result.status    = err_d;
		priority if (phase_d == tdpa_pkg::PH_COPY || phase_d == tdpa_pkg::PH_SKIP) begin
			result.need_next = tdpa_pkg::NEED_OLD;
		end else if (phase_d == tdpa_pkg::PH_IDLE || phase_d == tdpa_pkg::PH_END) begin
			result.need_next = tdpa_pkg::NEED_NONE;
		end else begin
			result.need_next = tdpa_pkg::NEED_DELTA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tdpa_pkg::PH_IDLE;
			acc_q    <= '0;
			rem_q    <= '0;
			pos_q    <= '0;
			size_q   <= '0;
			digits_q <= 1'b0;
			token_q  <= 1'b0;
			err_q    <= tdpa_pkg::ST_OK;
		end else if (step_en) begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			rem_q    <= rem_d;
			pos_q    <= pos_d;
			size_q   <= size_d;
			digits_q <= digits_d;
			token_q  <= token_d;
			err_q    <= err_d;
		end
	end

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= size_q)
		else $error("old position past old length");

	a_move_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == tdpa_pkg::PH_COPY || phase_q == tdpa_pkg::PH_SKIP ||
		 phase_q == tdpa_pkg::PH_INSERT) |-> rem_q != '0)
		else $error("byte-moving phase with zero count");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == tdpa_pkg::PH_END && err_q != tdpa_pkg::ST_OK && step_en &&
		 op != tdpa_pkg::OP_START) |=> (phase_q == tdpa_pkg::PH_END && $stable(err_q)))
		else $error("failure not sticky");

endmodule

// ----- src/text_delta_patch_applier.sv -----
// Top level: input register, patch state machine, result register.
// Path: a word taken passes the input register, then the result register;
//   result_valid rises when the result register loads; a held result stalls that load.
// Throughput: one word per cycle, set by the single-step update, unless output stalls.
// Reset: arst_n clears the valid flags of both register stages and the job state to idle.
`timescale 1ns / 1ps

module text_delta_patch_applier #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic [1:0]  need_next,
	output logic        done_res,
	output logic [2:0]  status
);

	logic              vld_s1;
	logic [1:0]        op_s1;
	logic [31:0]       data_s1;
	logic              vld_s2;
	tdpa_pkg::result_t res_s2;
	tdpa_pkg::result_t res_next;
	logic              advance;

	assign advance    = vld_s1 && (!vld_s2 || result_ready);
	assign item_ready = !vld_s1 || advance;

	tdpa_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(advance),
		.op     (op_s1),
		.data   (data_s1),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1   <= operation;
			data_s1 <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (result_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid = vld_s2;
	assign out_valid    = res_s2.out_valid;
	assign out_byte     = res_s2.out_byte;
	assign need_next    = res_s2.need_next;
	assign done_res     = res_s2.done_res;
	assign status       = res_s2.status;

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && !result_ready))
		else $error("input stalled without output back-pressure");

	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && done_res) |-> (status == tdpa_pkg::ST_OK &&
		 need_next == tdpa_pkg::NEED_NONE))
		else $error("done with error or live job");

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != tdpa_pkg::ST_OK) |->
		(need_next == tdpa_pkg::NEED_NONE && !out_valid))
		else $error("error code while job running");

	a_byte_live: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_valid) |-> need_next != tdpa_pkg::NEED_NONE)
		else $error("byte emitted by a finished job");

endmodule

// ----- test/tdpa_checker.sv -----
// Checker for the text delta patch applier: predicts each result word and compares it.
`timescale 1ns / 1ps

module tdpa_checker
	import tdpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] data,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic        out_valid,
	input  logic [7:0]  out_byte,
	input  logic [1:0]  need_next,
	input  logic        done_res,
	input  logic [2:0]  status,
	output int          fail_count,
	output int          pending
);

	phase_t      ph;
	logic [31:0] acc;
	logic [31:0] remain;
	logic [31:0] opos;
	logic [31:0] osize;
	logic        digits;
	logic        started;
	logic [2:0]  err;
	result_t     expected_q[$];
	int          errs;

	function automatic logic is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic clear_job();
		ph = PH_IDLE;
		acc = '0;
		remain = '0;
		opos = '0;
		osize = '0;
		digits = 1'b0;
		started = 1'b0;
		err = ST_OK;
	endtask

	task automatic end_job(logic [2:0] code);
		ph = PH_END;
		err = code;
	endtask

	task automatic open_op();
		ph = PH_NUM;
		acc = '0;
		digits = 1'b0;
		started = 1'b0;
	endtask

	task automatic take_op(logic [7:0] c);
		if (c == CH_COPY || c == CH_SKIP) begin
			if ({1'b0, opos} + {1'b0, acc} > {1'b0, osize}) begin
				end_job(ST_OVERRUN);
			end else if (acc == 0) begin
				open_op();
			end else begin
				remain = acc;
				ph = (c == CH_COPY) ? PH_COPY : PH_SKIP;
			end
		end else if (c == CH_INS) begin
			remain = acc;
			ph = (acc == 0) ? PH_DELIM : PH_INSERT;
		end else begin
			end_job(ST_UNKNOWN);
		end
	endtask

	task automatic patch_step(item_op_t op, logic [31:0] d, output result_t r);
		logic [7:0]  c;
		logic [35:0] next_acc;
		c = d[7:0];
		r = '0;
		if (op == OP_START) begin
			clear_job();
			osize = d;
			open_op();
		end else if (ph == PH_END && err != ST_OK) begin
			// hold the failure until the next start
		end else if (ph == PH_IDLE || ph == PH_END) begin
			end_job(ST_KIND);
		end else if (op == OP_DELTA) begin
			case (ph)
				PH_NUM: begin
					if (is_blank(c)) begin
						if (digits) ph = PH_OP;
						else started = 1'b1;
					end else if (c >= CH_ZERO && c <= CH_NINE) begin
						next_acc = {4'b0, acc} * 36'd10 + {28'b0, c - CH_ZERO};
						if (next_acc > 36'hFFFF_FFFF) begin
							end_job(ST_MALFORMED);
						end else begin
							acc = next_acc[31:0];
							digits = 1'b1;
							started = 1'b1;
						end
					end else if (digits) begin
						take_op(c);
					end else begin
						end_job(ST_MALFORMED);
					end
				end
				PH_OP: begin
					if (!is_blank(c)) take_op(c);
				end
				PH_INSERT: begin
					r.out_valid = 1'b1;
					r.out_byte = c;
					remain = remain - 1;
					if (remain == 0) ph = PH_DELIM;
				end
				PH_DELIM: begin
					if (!is_blank(c)) begin
						if (c == CH_BAR) open_op();
						else end_job(ST_DELIM);
					end
				end
				default: end_job(ST_KIND);
			endcase
		end else if (op == OP_OLD) begin
			if (ph != PH_COPY && ph != PH_SKIP) begin
				end_job(ST_KIND);
			end else begin
				if (ph == PH_COPY) begin
					r.out_valid = 1'b1;
					r.out_byte = c;
				end
				opos = opos + 1;
				remain = remain - 1;
				if (remain == 0) open_op();
			end
		end else begin
			case (ph)
				PH_NUM: begin
					if (started) end_job(ST_MALFORMED);
					else if (opos != osize) end_job(ST_MISMATCH);
					else end_job(ST_OK);
				end
				PH_OP, PH_INSERT, PH_DELIM: end_job(ST_MALFORMED);
				default: end_job(ST_KIND);
			endcase
		end
		if (ph == PH_COPY || ph == PH_SKIP) r.need_next = NEED_OLD;
		else if (ph == PH_IDLE || ph == PH_END) r.need_next = NEED_NONE;
		else r.need_next = NEED_DELTA;
		r.done_res = (ph == PH_END && err == ST_OK);
		r.status = err;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			clear_job();
			expected_q.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				got = {out_valid, out_byte, need_next, done_res, status};
				if (expected_q.size() == 0) begin
					if (errs < 10)
						$display("unexpected result word: v=%0d b=%h n=%0d d=%0d s=%0d",
							got.out_valid, got.out_byte, got.need_next, got.done_res,
							got.status);
					errs++;
				end else begin
					want = expected_q.pop_front();
					if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
						got.need_next !== want.need_next || got.done_res !== want.done_res ||
						got.status !== want.status) begin
						if (errs < 10)
							$display("mismatch: expected v=%0d b=%h n=%0d d=%0d s=%0d, got v=%0d b=%h n=%0d d=%0d s=%0d",
								want.out_valid, want.out_byte, want.need_next, want.done_res,
								want.status, got.out_valid, got.out_byte, got.need_next,
								got.done_res, got.status);
						errs++;
					end
				end
			end
			if (item_valid && item_ready) begin
				patch_step(item_op_t'(operation), data, want);
				expected_q.push_back(want);
			end
			fail_count <= errs;
			pending <= expected_q.size();
		end
	end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the text delta patch applier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import tdpa_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT = 400;
	localparam int HOLD_LEN = 400;

	typedef struct {
		item_op_t    op;
		logic [31:0] d;
	} word_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [1:0]  operation;
	logic [31:0] data;
	logic        result_valid;
	logic        result_ready;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic [1:0]  need_next;
	logic        done_res;
	logic [2:0]  status;
	int          fail_count;
	int          pending;
	int          cycle_cnt = 0;
	logic        calm = 1'b0;
	word_t       job[$];

	text_delta_patch_applier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.operation   (operation),
		.data        (data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.need_next   (need_next),
		.done_res    (done_res),
		.status      (status)
	);

	tdpa_checker chk (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] pad(logic [7:0] c);
		logic [31:0] r;
		r = $urandom();
		return {r[31:8], c};
	endfunction

	task automatic put(item_op_t op, logic [7:0] c);
		word_t w;
		w.op = op;
		w.d = pad(c);
		job.push_back(w);
	endtask

	task automatic put_start(logic [31:0] len);
		word_t w;
		w.op = OP_START;
		w.d = len;
		job.push_back(w);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put(OP_DELTA, s[i]);
	endtask

	task automatic put_blanks(int n);
		repeat (n)
			put(OP_DELTA, ($urandom_range(0, 5) == 5) ? CH_SPACE :
				CH_TAB + 8'($urandom_range(0, 4)));
	endtask

	task automatic send_word(item_op_t op, logic [31:0] d);
		while (!calm && $urandom_range(0, 99) < 11) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		data <= d;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	task automatic run_job();
		foreach (job[i])
			send_word(job[i].op, job[i].d);
		job.delete();
	endtask

	// Well-formed delta with random ops and content; some jobs get one defect.
	task automatic build_job();
		int          defect;
		int          n;
		int          kind;
		int          pos;
		logic [31:0] total;
		word_t       w;
		total = 0;
		job.delete();
		defect = ($urandom_range(0, 99) < 35) ? $urandom_range(0, 9) : -1;
		if (defect == 6) begin
			if ($urandom_range(0, 1)) put_text("4294967296");
			else put_text($sformatf("%0d", $urandom()));
			put(OP_DELTA, ($urandom_range(0, 1)) ? CH_SKIP : CH_COPY);
		end else if (defect == 8) begin
			put(OP_DELTA, ($urandom_range(0, 1)) ? CH_SKIP : CH_INS);
		end
		repeat ($urandom_range(0, 5)) begin
			kind = $urandom_range(0, 2);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
			put_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
			if ($urandom_range(0, 7) == 0) put(OP_DELTA, CH_ZERO);
			put_text($sformatf("%0d", n));
			put_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
			case (kind)
				0, 1: begin
					put(OP_DELTA, (kind == 0) ? CH_COPY : CH_SKIP);
					repeat (n) put(OP_OLD, 8'($urandom_range(0, 255)));
					total += n;
				end
				default: begin
					put(OP_DELTA, CH_INS);
					repeat (n) put(OP_DELTA, 8'($urandom_range(0, 255)));
					put_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
					put(OP_DELTA, CH_BAR);
				end
			endcase
		end
		put(OP_EOD, 8'($urandom_range(0, 255)));
		w.op = OP_START;
		w.d = total;
		job.push_front(w);
		case (defect)
			0: job[0].d = total + $urandom_range(1, 3);
			1: job[0].d = (total > 0) ? total - 1 : $urandom();
			2: begin
				pos = $urandom_range(1, job.size() - 1);
				job[pos].d[7:0] = 8'($urandom_range(0, 255));
			end
			3: begin
				w.op = item_op_t'($urandom_range(1, 3));
				w.d = $urandom();
				job.insert($urandom_range(1, job.size()), w);
			end
			4: if (job.size() > 2) job.delete($urandom_range(1, job.size() - 2));
			5: begin
				w.op = OP_DELTA;
				w.d = pad(CH_SPACE);
				job.insert(job.size() - 1, w);
			end
			7: void'(job.pop_back());
			default: ;
		endcase
	endtask

	initial begin : rx
		int n;
		n = 0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			n++;
			if (n == HOLD_AT) begin
				result_ready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end
			result_ready <= calm || $urandom_range(0, 99) >= 11;
		end
	end

	initial begin : tx
		int sent;
		arst_n = 1'b0;
		item_valid = 1'b0;
		operation = OP_START;
		data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put(OP_DELTA, "x");
		put_start(2);
		put_text(" 1=");
		put(OP_OLD, 8'hFF);
		put_text("0-1+");
		put(OP_DELTA, CH_BAR);
		put(OP_DELTA, CH_TAB);
		put(OP_DELTA, CH_BAR);
		put_text("1-");
		put(OP_OLD, 8'h00);
		put(OP_EOD, 8'h00);
		put(OP_DELTA, CH_NINE);
		put_start(32'hFFFF_FFFF);
		put(OP_DELTA, CH_SKIP);
		put(OP_EOD, 8'hFF);
		put_start(0);
		put_text("9=");
		put_start(1);
		put_text("1*");
		put_start(1);
		put_text("1=");
		put(OP_EOD, 8'h00);
		run_job();

		sent = 0;
		while (sent < 900) begin
			calm = (sent >= 300 && sent < 500);
			if ($urandom_range(0, 99) < 5) begin
				if ($urandom_range(0, 3) == 0) put_start($urandom_range(0, 8));
				else put(item_op_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
			end else begin
				build_job();
			end
			sent += job.size();
			run_job();
		end
		calm = 1'b0;
		item_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- text_delta_patch_applier.f -----
src/tdpa_pkg.sv
src/tdpa_core.sv
src/text_delta_patch_applier.sv
test/tdpa_checker.sv
test/tb_top.sv
